// ----- rtl/src_pkg.sv -----
// Shared constants, types and control structs for the scored record cache.
// No dependencies; every other file except src_ram imports this package.
package src_pkg;

    localparam int ENTRIES    = 16;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int KEY_W      = 32;
    localparam int SCORE_W    = 16;
    localparam int INC_W      = 10;
    localparam int DEC_W      = 11;
    localparam int AGE_W      = SCORE_W + 2;
    localparam int OUT_CNT_W  = 5;
    localparam int ENTRY_W    = KEY_W + SCORE_W;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DEC_W;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_INC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_DEC = 1'b1;

    localparam logic [INC_W-1:0] INC_RESET = 10'd5;
    localparam logic [DEC_W-1:0] DEC_RESET = 11'h7FF;

    // controller -> datapath
    typedef struct packed {
        logic start;
        logic rd_walk;
        logic rd_move;
        logic rd_fill;
        logic walk_eval;
        logic move_step;
        logic move_commit;
        logic fill_wr;
        logic out_load;
    } src_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic walk_stop;
        logic eval_hit;
        logic move_stop;
        logic move_le;
        logic fill_go;
        logic out_full;
    } src_sts_t;

endpackage

// ----- rtl/src_req_if.sv -----
// Request channel: valid/ready handshake carrying mode and record id.
// Depends on src_pkg.
interface src_req_if import src_pkg::*;;
    logic             valid;
    logic             ready;
    logic             mode;
    logic [KEY_W-1:0] record_id;

    modport source (output valid, mode, record_id, input ready);
    modport sink   (input valid, mode, record_id, output ready);
endinterface

// ----- rtl/src_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one result per request.
// Depends on src_pkg.
interface src_rsp_if import src_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic                 filled;
    logic                 evicted;
    logic [KEY_W-1:0]     evicted_id;
    logic [OUT_CNT_W-1:0] aged_out;
    logic [OUT_CNT_W-1:0] occupancy;

    modport source (output valid, hit, filled, evicted, evicted_id, aged_out, occupancy,
                    input ready);
    modport sink   (input valid, hit, filled, evicted, evicted_id, aged_out, occupancy,
                    output ready);
endinterface

// ----- rtl/src_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module src_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/src_ctrl.sv -----
// Sequencer for the cache walk: read, evaluate, move-up, fill, respond.
// Depends on src_pkg; drives src_dp through src_cmd_t.
module src_ctrl import src_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  src_sts_t sts,
    output src_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_W_ADDR  = 3'd1;
    localparam logic [2:0] ST_W_EVAL  = 3'd2;
    localparam logic [2:0] ST_M_ADDR  = 3'd3;
    localparam logic [2:0] ST_M_EVAL  = 3'd4;
    localparam logic [2:0] ST_FILL_RD = 3'd5;
    localparam logic [2:0] ST_FILL_WR = 3'd6;
    localparam logic [2:0] ST_DONE    = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign req_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_W_ADDR;
                end
            end
            ST_W_ADDR:
            begin
                if (sts.walk_stop)
                begin
                    state_next = sts.fill_go ? ST_FILL_RD : ST_DONE;
                end
                else
                begin
                    cmd.rd_walk = 1'b1;
                    state_next  = ST_W_EVAL;
                end
            end
            ST_W_EVAL:
            begin
                cmd.walk_eval = 1'b1;
                state_next    = sts.eval_hit ? ST_M_ADDR : ST_W_ADDR;
            end
            ST_M_ADDR:
            begin
                if (sts.move_stop)
                begin
                    cmd.move_commit = 1'b1;
                    state_next      = ST_W_ADDR;
                end
                else
                begin
                    cmd.rd_move = 1'b1;
                    state_next  = ST_M_EVAL;
                end
            end
            ST_M_EVAL:
            begin
                if (sts.move_le)
                begin
                    cmd.move_step = 1'b1;
                    state_next    = ST_M_ADDR;
                end
                else
                begin
                    cmd.move_commit = 1'b1;
                    state_next      = ST_W_ADDR;
                end
            end
            ST_FILL_RD:
            begin
                cmd.rd_fill = 1'b1;
                state_next  = ST_FILL_WR;
            end
            ST_FILL_WR:
            begin
                cmd.fill_wr = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (!sts.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/src_dp.sv -----
// Datapath: entry RAM, valid bits, rank list, walk counters, config, result beat.
// Depends on src_pkg and src_ram; sequenced by src_ctrl.
module src_dp import src_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_mode,
    input  logic [KEY_W-1:0]      req_id,
    input  src_cmd_t              cmd,
    output src_sts_t              sts,
    src_rsp_if.source             rsp
);

    // configuration
    logic [INC_W-1:0] inc_reg;
    logic [DEC_W-1:0] dec_reg;

    // cache state
    logic [ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0]   rank_reg [ENTRIES];
    logic [CNT_W-1:0]   count_reg;

    // per-request state
    logic               mode_reg;
    logic [KEY_W-1:0]   id_reg;
    logic [CNT_W-1:0]   k_reg;
    logic [IDX_W-1:0]   u_reg;
    logic               hit_reg;
    logic [SCORE_W-1:0] hs_reg;
    logic [IDX_W-1:0]   hs_slot_reg;
    logic [IDX_W-1:0]   cur_slot_reg;
    logic [IDX_W-1:0]   mv_slot_reg;
    logic [IDX_W-1:0]   tail_reg;
    logic [SCORE_W-1:0] prev_reg;
    logic               have_ins_reg;
    logic [IDX_W-1:0]   ins_reg;
    logic [CNT_W-1:0]   aged_reg;
    logic               filled_reg;
    logic               evicted_reg;
    logic [KEY_W-1:0]   evid_reg;

    // result beat
    logic                 out_valid_reg;
    logic                 out_hit_reg;
    logic                 out_filled_reg;
    logic                 out_evicted_reg;
    logic [KEY_W-1:0]     out_evid_reg;
    logic [OUT_CNT_W-1:0] out_aged_reg;
    logic [OUT_CNT_W-1:0] out_occ_reg;

    // RAM ports
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [KEY_W-1:0]   rd_key;
    logic [SCORE_W-1:0] rd_score;

    // combinational helpers
    logic [IDX_W-1:0]   k_idx;
    logic [IDX_W-1:0]   rank_sel;
    logic [IDX_W-1:0]   slot_sel;
    logic [SCORE_W:0]   hit_sum;
    logic [SCORE_W-1:0] hit_score;
    logic [AGE_W-1:0]   age_sum;
    logic               age_empty;
    logic [SCORE_W-1:0] age_score;
    logic               ins_here;
    logic [SCORE_W-1:0] mv_score;
    logic [IDX_W-1:0]   ins_use;

    src_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key   = ram_rdata[ENTRY_W-1:SCORE_W];
    assign rd_score = ram_rdata[SCORE_W-1:0];
    assign k_idx    = k_reg[IDX_W-1:0];

    // one rank lookup per cycle: walk position, move-up predecessor or tail
    always_comb
    begin
        if (cmd.rd_move)
        begin
            rank_sel = u_reg - 1'b1;
        end
        else if (cmd.rd_fill)
        begin
            rank_sel = IDX_W'(ENTRIES - 1);
        end
        else
        begin
            rank_sel = k_idx;
        end
    end
    assign slot_sel  = rank_reg[rank_sel];
    assign ram_re    = cmd.rd_walk | cmd.rd_move | cmd.rd_fill;
    assign ram_raddr = slot_sel;

    // hit score, saturating
    assign hit_sum   = (SCORE_W+1)'(rd_score) + (SCORE_W+1)'(inc_reg);
    assign hit_score = hit_sum[SCORE_W] ? SCORE_MAX : hit_sum[SCORE_W-1:0];

    // aging: signed add, empty at zero or below, saturate on the high side
    assign age_sum   = AGE_W'(rd_score) + {{(AGE_W-DEC_W){dec_reg[DEC_W-1]}}, dec_reg};
    assign age_empty = age_sum[AGE_W-1] || (age_sum == '0);
    always_comb
    begin
        if (age_empty)
        begin
            age_score = '0;
        end
        else if (age_sum[AGE_W-2:SCORE_W] != '0)
        begin
            age_score = SCORE_MAX;
        end
        else
        begin
            age_score = age_sum[SCORE_W-1:0];
        end
    end
    assign ins_here = (age_score <= SCORE_W'(inc_reg))
                    && ((k_reg == '0) || (prev_reg > SCORE_W'(inc_reg)));

    // never-written entries are always invalid and score as zero
    assign mv_score = valid_reg[mv_slot_reg] ? rd_score : '0;
    assign ins_use  = have_ins_reg ? ins_reg : k_idx;

    // RAM write: hit update, aging, fill
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cur_slot_reg;
        ram_wdata = {rd_key, age_score};
        if (cmd.walk_eval)
        begin
            ram_we    = 1'b1;
            ram_wdata = sts.eval_hit ? {rd_key, hit_score} : {rd_key, age_score};
        end
        else if (cmd.fill_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = tail_reg;
            ram_wdata = {id_reg, SCORE_W'(inc_reg)};
        end
    end

    // status
    assign sts.walk_stop = (k_reg == CNT_W'(ENTRIES)) || !valid_reg[slot_sel];
    assign sts.eval_hit  = !hit_reg && (rd_key == id_reg);
    assign sts.move_stop = (u_reg == '0);
    assign sts.move_le   = (mv_score <= hs_reg);
    assign sts.fill_go   = !hit_reg && mode_reg
                         && (have_ins_reg || (k_reg != CNT_W'(ENTRIES)));
    assign sts.out_full  = out_valid_reg && !rsp.ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inc_reg <= INC_RESET;
            dec_reg <= DEC_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCORE_INC: inc_reg <= cfg_data[INC_W-1:0];
                CFG_SCORE_DEC: dec_reg <= cfg_data[DEC_W-1:0];
                default:       ;
            endcase
        end
    end

    // cache state: valid bits, rank list, occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= IDX_W'(i);
            end
        end
        else
        begin
            if (cmd.walk_eval && !sts.eval_hit && age_empty)
            begin
                valid_reg[cur_slot_reg] <= 1'b0;
                if (count_reg != '0)
                begin
                    count_reg <= count_reg - 1'b1;
                end
            end
            // hit entry moves up to rank u, u..k-1 shift down
            if (cmd.move_commit)
            begin
                for (int j = 0; j < ENTRIES; j++)
                begin
                    if (j == int'(u_reg))
                    begin
                        rank_reg[j] <= hs_slot_reg;
                    end
                    else if (j > int'(u_reg) && j <= int'(k_reg))
                    begin
                        rank_reg[j] <= rank_reg[j-1];
                    end
                end
            end
            // filled tail slot is linked at the insertion point
            if (cmd.fill_wr)
            begin
                valid_reg[tail_reg] <= 1'b1;
                if (!valid_reg[tail_reg] && count_reg < CNT_W'(ENTRIES))
                begin
                    count_reg <= count_reg + 1'b1;
                end
                for (int j = 0; j < ENTRIES; j++)
                begin
                    if (j == int'(ins_use))
                    begin
                        rank_reg[j] <= tail_reg;
                    end
                    else if (j > int'(ins_use))
                    begin
                        rank_reg[j] <= rank_reg[j-1];
                    end
                end
            end
        end
    end

    // walk control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg        <= '0;
            u_reg        <= '0;
            hit_reg      <= 1'b0;
            have_ins_reg <= 1'b0;
            aged_reg     <= '0;
            filled_reg   <= 1'b0;
            evicted_reg  <= 1'b0;
            mode_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                k_reg        <= '0;
                hit_reg      <= 1'b0;
                have_ins_reg <= 1'b0;
                aged_reg     <= '0;
                filled_reg   <= 1'b0;
                evicted_reg  <= 1'b0;
                mode_reg     <= req_mode;
            end
            if (cmd.walk_eval)
            begin
                if (sts.eval_hit)
                begin
                    hit_reg <= 1'b1;
                    u_reg   <= k_idx;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                    if (age_empty)
                    begin
                        aged_reg <= aged_reg + 1'b1;
                    end
                    if (ins_here)
                    begin
                        have_ins_reg <= 1'b1;
                    end
                end
            end
            if (cmd.move_step)
            begin
                u_reg <= u_reg - 1'b1;
            end
            if (cmd.move_commit)
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (cmd.fill_wr)
            begin
                filled_reg  <= 1'b1;
                evicted_reg <= valid_reg[tail_reg];
            end
        end
    end

    // walk payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            id_reg   <= req_id;
            evid_reg <= '0;
        end
        if (cmd.rd_walk)
        begin
            cur_slot_reg <= slot_sel;
        end
        if (cmd.rd_move)
        begin
            mv_slot_reg <= slot_sel;
        end
        if (cmd.rd_fill)
        begin
            tail_reg <= slot_sel;
        end
        if (cmd.walk_eval)
        begin
            if (sts.eval_hit)
            begin
                hs_reg      <= hit_score;
                hs_slot_reg <= cur_slot_reg;
            end
            else
            begin
                prev_reg <= age_score;
                if (ins_here)
                begin
                    ins_reg <= k_idx;
                end
            end
        end
        // predecessor of the next rank is the hit entry only if it stayed put
        if (cmd.move_commit && u_reg == k_idx)
        begin
            prev_reg <= hs_reg;
        end
        if (cmd.fill_wr && valid_reg[tail_reg])
        begin
            evid_reg <= rd_key;
        end
    end

    // result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_hit_reg     <= hit_reg;
            out_filled_reg  <= filled_reg;
            out_evicted_reg <= evicted_reg;
            out_evid_reg    <= evid_reg;
            out_aged_reg    <= OUT_CNT_W'(aged_reg);
            out_occ_reg     <= OUT_CNT_W'(count_reg);
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.filled     = out_filled_reg;
    assign rsp.evicted    = out_evicted_reg;
    assign rsp.evicted_id = out_evid_reg;
    assign rsp.aged_out   = out_aged_reg;
    assign rsp.occupancy  = out_occ_reg;

endmodule

// ----- rtl/scored_record_cache.sv -----
// Top level of the scored record cache: controller plus datapath.
// Depends on src_pkg, src_req_if, src_rsp_if, src_ctrl, src_dp.
//
// Usage:
//   req  - request beats (mode, record_id); ready is high only while idle.
//   rsp  - one result beat per request, held in an output register until taken.
//   cfg  - cfg_we/cfg_index/cfg_data write score_increment (0) and
//          score_decrement (1); write only while no request is in flight.
// Sequence: one request at a time. The walk visits each entry with an entry RAM
// read, then evaluate/write back; a hit climbs rank by rank, each with a read
// and a compare, and ends when a predecessor outscores it or at rank zero; a
// fill reads the tail rank and then writes it. Accept, the end-of-walk check
// and result load are steps of their own.
// Reset clears all entries to empty, ranks to identity order and the control and
// configuration registers to their defaults; no clearing pass is needed.
// A stalled receiver holds the result beat; the next request is accepted
// meanwhile, and its result waits in the final step until the register frees.
module scored_record_cache import src_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    src_req_if.sink               req,
    src_rsp_if.source             rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    src_cmd_t cmd;
    src_sts_t sts;

    src_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    src_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_mode  (req.mode),
        .req_id    (req.record_id),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (rsp)
    );

endmodule
